// ===== src/oaht_pkg.sv =====
// Shared types and constants of the open addressing hash table.
package oaht_pkg;

    localparam int KEY_NBYTES = 16;
    localparam int BYTE_W = 8;
    localparam int KEY_W = KEY_NBYTES * BYTE_W;
    localparam int HALF_W = KEY_W / 2;
    localparam int SLOT_W = 10;
    localparam int STATUS_W = 2;
    localparam int OUT_DATA_W = 16;

    localparam int DEF_TABLE_SIZE = 1009;
    localparam int DEF_KEY_BYTES = 16;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                clr_wr;
        logic                load;
        logic                sum;
        logic                mod_step;
        logic                home;
        logic                rd;
        logic                adv;
        logic                key_wr;
        logic                res_set;
        logic [STATUS_W-1:0] res_status;
        logic                res_slot;
        logic                out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic key_zero;
        logic mod_done;
        logic hit;
        logic empty;
        logic last_probe;
        logic is_search;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== src/oaht_ctrl.sv =====
// Controller state machine of the hash table: sequences clearing, hashing and probing.
module oaht_ctrl
    import oaht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.res_status = ST_MISS;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (i_stat.key_zero) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_status = ST_MISS;
                    n_state = S_DONE;
                end else begin
                    o_cmd.sum = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    o_cmd.home = 1'b1;
                    n_state = S_READ;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.hit) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_slot = 1'b1;
                    n_state = S_DONE;
                end else if (i_stat.empty) begin
                    o_cmd.res_set = 1'b1;
                    if (i_stat.is_search) begin
                        o_cmd.res_status = ST_MISS;
                    end else begin
                        o_cmd.key_wr = 1'b1;
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_slot = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (i_stat.last_probe) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_status = i_stat.is_search ? ST_MISS : ST_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== src/oaht_dp.sv =====
// Datapath of the hash table: key normalisation, home slot reduction, slot memory and result register.
module oaht_dp
    import oaht_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int KEY_BYTES  = DEF_KEY_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_func,
    input  logic [HALF_W-1:0]     i_key_hi,
    input  logic [HALF_W-1:0]     i_key_lo,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int MAX_SUM = 255 * KEY_BYTES;
    localparam int SUM_W = $clog2(MAX_SUM + 1);
    localparam int MOD_STEPS = $clog2(MAX_SUM / TABLE_SIZE + 1);
    localparam int MC_W = (MOD_STEPS > 0) ? $clog2(MOD_STEPS + 1) : 1;
    localparam int CW = SUM_W + IDX_W + 1;

    logic                  r_func;
    logic [KEY_W-1:0]      r_key;
    logic [KEY_W-1:0]      n_key;
    logic [SUM_W-1:0]      r_rem;
    logic [SUM_W-1:0]      n_sum;
    logic [MC_W-1:0]       r_mod_cnt;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_cnt;
    logic [KEY_W-1:0]      r_rd_data;
    logic [STATUS_W-1:0]   r_res_status;
    logic [SLOT_W-1:0]     r_res_slot;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [SLOT_W-1:0]     r_out_slot;

    logic [KEY_W-1:0]      mem [TABLE_SIZE];

    logic [CW-1:0]         rem_w;
    logic [CW-1:0]         sub_d;
    logic [CW-1:0]         sub_diff;
    logic [MC_W-1:0]       shift_k;
    logic [SUM_W+IDX_W-1:0] home_ext;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    // Keep bytes up to the first zero byte or the key length, clear the rest.
    always_comb begin
        logic       ended;
        logic [KEY_W-1:0] raw;
        logic [BYTE_W-1:0] b;
        ended = 1'b0;
        raw = {i_key_hi, i_key_lo};
        n_key = '0;
        for (int i = 0; i < KEY_NBYTES; i++) begin
            b = raw[KEY_W-1-BYTE_W*i -: BYTE_W];
            if (i >= KEY_BYTES || b == '0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                n_key[KEY_W-1-BYTE_W*i -: BYTE_W] = b;
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < KEY_NBYTES; i++) begin
            n_sum = n_sum + SUM_W'(r_key[KEY_W-1-BYTE_W*i -: BYTE_W]);
        end
    end

    // One restoring step of the reduction modulo the table size per cycle.
    assign shift_k  = r_mod_cnt - 1'b1;
    assign rem_w    = CW'(r_rem);
    assign sub_d    = CW'(TABLE_SIZE) << shift_k;
    assign sub_diff = rem_w - sub_d;
    assign home_ext = {{IDX_W{1'b0}}, r_rem};
    assign slot_ext = {{SLOT_W{1'b0}}, r_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_key  <= n_key;
        end
        if (i_cmd.sum) begin
            r_rem <= n_sum;
        end else if (i_cmd.mod_step && rem_w >= sub_d) begin
            r_rem <= sub_diff[SUM_W-1:0];
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_slot   <= i_cmd.res_slot ? slot_ext[SLOT_W-1:0] : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_cnt   <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.sum) begin
                r_mod_cnt <= MC_W'(MOD_STEPS);
            end else if (i_cmd.mod_step) begin
                r_mod_cnt <= shift_k;
            end
            if (i_cmd.clr_wr) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.home) begin
                r_idx <= home_ext[IDX_W-1:0];
            end else if (i_cmd.adv) begin
                r_idx <= (r_idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.home) begin
                r_cnt <= '0;
            end else if (i_cmd.adv) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Slot key memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr || i_cmd.key_wr) begin
            mem[r_idx] <= i_cmd.clr_wr ? '0 : r_key;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[r_idx];
        end
    end

    assign o_stat.clr_done   = (r_idx == IDX_W'(TABLE_SIZE - 1));
    assign o_stat.key_zero   = (r_key == '0);
    assign o_stat.mod_done   = (r_mod_cnt == '0);
    assign o_stat.hit        = (r_rd_data == r_key);
    assign o_stat.empty      = (r_rd_data == '0);
    assign o_stat.last_probe = (r_cnt == IDX_W'(TABLE_SIZE - 1));
    assign o_stat.is_search  = (r_func == FUNC_SEARCH);
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - SLOT_W - STATUS_W){1'b0}}, r_out_slot, r_out_status};

endmodule

// ===== src/open_address_hash_table.sv =====
// Top level of the open addressing hash table with linear probing.
//
// The block keeps a table of TABLE_SIZE slots, each holding one key of up to sixteen bytes,
// and takes one insert or search item at a time. A key is read as a zero-terminated string:
// bytes after the first zero byte, or beyond KEY_BYTES, are treated as zero, and a key whose
// first byte is zero is answered with "not found" and changes nothing. The home slot is the
// sum of the key bytes reduced modulo TABLE_SIZE, and probing walks forward one slot at a time,
// wrapping to slot zero. An insert stops at its own key or fills the first empty slot; a search
// stops at its key or at an empty slot. Each item yields one result item carrying a status
// (0 stored or found, 1 not found, 2 table full) and the slot, which is zero unless the status
// is 0. After reset the block sweeps the whole slot memory to zero, one slot per cycle, and it
// accepts its first item only once the sweep has ended. An item is then summed, reduced over
// MOD_STEPS restoring steps of the home slot reduction (three for the default sizes), and
// probed slot by slot until it ends; an empty key skips the reduction and the probes. Each probe
// takes a read state and a compare state because the slot memory has a single registered
// read port and the key compare follows the read. The result waits in an output register,
// so the block takes the next item while a result is still waiting to be taken.
module open_address_hash_table
    import oaht_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int KEY_BYTES  = DEF_KEY_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [KEY_W-1:0]      i_s_tdata,   // key_hi [63:0], key_lo [127:64]
    input  logic                  i_s_tuser,   // func: 0 insert, 1 search
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // status [1:0], slot [11:2], zero [15:12]
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // The controller sequences clearing, hashing, probing and the result hand-over.
    oaht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the slot memory, the working key and the output register.
    oaht_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BYTES  (KEY_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_func     (i_s_tuser),
        .i_key_hi   (i_s_tdata[HALF_W-1:0]),
        .i_key_lo   (i_s_tdata[KEY_W-1:HALF_W]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== verif/open_address_hash_table_checker.sv =====
// Checker for the open addressing hash table: predicts each answer and compares it.
module open_address_hash_table_checker
    import oaht_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int KEY_BYTES  = DEF_KEY_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [KEY_W-1:0]      i_s_tdata,   // key_hi [63:0], key_lo [127:64]
    input  logic                  i_s_tuser,   // func: 0 insert, 1 search
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // status [1:0], slot [11:2], zero [15:12]
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_lookup_answer;

    // Keys are held with byte 0 in the top byte of the vector.
    logic [KEY_W-1:0] slot_store [TABLE_SIZE];
    t_lookup_answer   awaited_answers [$];
    int               mismatches = 0;

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Runs one insert or search against the local copy of the table.
    task automatic probe_table(input logic func, input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0]  key;
        logic [BYTE_W-1:0] b;
        int unsigned       sum;
        int unsigned       idx;
        bit                ended;
        t_lookup_answer    ans;
        key   = '0;
        sum   = 0;
        ended = 1'b0;
        for (int i = 0; i < KEY_NBYTES; i++) begin
            b = raw[KEY_W-1-BYTE_W*i -: BYTE_W];
            if (i >= KEY_BYTES || b == '0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                sum += b;
                key[KEY_W-1-BYTE_W*i -: BYTE_W] = b;
            end
        end
        ans.status = ST_MISS;
        ans.slot   = '0;
        if (key != '0) begin
            idx = sum % TABLE_SIZE;
            if (func == FUNC_INSERT) begin
                ans.status = ST_FULL;
            end
            for (int n = 0; n < TABLE_SIZE; n++) begin
                if (slot_store[idx] == key) begin
                    ans.status = ST_OK;
                    ans.slot   = idx[SLOT_W-1:0];
                    break;
                end
                if (slot_store[idx] == '0) begin
                    if (func == FUNC_SEARCH) begin
                        ans.status = ST_MISS;
                    end else begin
                        slot_store[idx] = key;
                        ans.status      = ST_OK;
                        ans.slot        = idx[SLOT_W-1:0];
                    end
                    break;
                end
                idx = (idx + 1 == TABLE_SIZE) ? 0 : idx + 1;
            end
        end
        awaited_answers.push_back(ans);
    endtask

    task automatic check_answer(input logic [OUT_DATA_W-1:0] d);
        t_lookup_answer want;
        if (awaited_answers.size() == 0) begin
            report_mismatch("answer with no operation outstanding", 0, d);
            return;
        end
        want = awaited_answers.pop_front();
        if (d[STATUS_W-1:0] != want.status) begin
            report_mismatch("status", want.status, d[STATUS_W-1:0]);
        end
        if (d[STATUS_W +: SLOT_W] != want.slot) begin
            report_mismatch("slot", want.slot, d[STATUS_W +: SLOT_W]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_SIZE; s++) begin
                slot_store[s] = '0;
            end
            awaited_answers.delete();
        end else begin
            // Answers are taken first so that an item accepted on the same edge
            // cannot be matched against an older answer.
            if (i_m_tvalid && i_m_tready) begin
                check_answer(i_m_tdata);
            end
            if (i_s_tvalid && i_s_tready) begin
                probe_table(i_s_tuser, {i_s_tdata[HALF_W-1:0], i_s_tdata[KEY_W-1:HALF_W]});
            end
        end
        o_fail_count = mismatches;
        o_pending    = awaited_answers.size();
    end

endmodule

// ===== verif/open_address_hash_table_tb.sv =====
// Testbench top of the open addressing hash table: stimulus, watchdog and verdict.
module open_address_hash_table_tb;
    import oaht_pkg::*;

    // The longest correct wait without any item moving is the clearing sweep after
    // reset or a full probe pass over every slot, plus the longest stall of either
    // side. The limit allows several times that.
    localparam int STALL_LIMIT = 16000;
    localparam int KEY_POOL_CAP = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [KEY_W-1:0]      s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    pending_count;
    int                    quiet_cycles = 0;
    logic                  full_answer_seen = 1'b0;
    bit                    tx_steady = 1'b0;
    bit                    rx_steady = 1'b0;

    // Keys sent with an insert (non-empty, up to KEY_POOL_CAP), kept so that later items can
    // revisit it, probe past it with an anagram, or hide junk behind its terminator.
    logic [KEY_W-1:0] key_pool [$];

    initial begin
        forever #2 clk = ~clk;
    end

    open_address_hash_table i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    open_address_hash_table_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Length of the string held in a key: the index of its first zero byte.
    function automatic int string_length(input logic [KEY_W-1:0] key);
        for (int i = 0; i < KEY_NBYTES; i++) begin
            if (key[KEY_W-1-BYTE_W*i -: BYTE_W] == '0) begin
                return i;
            end
        end
        return KEY_NBYTES;
    endfunction

    // A key of the given length with non-zero random characters, zero padded.
    function automatic logic [KEY_W-1:0] random_string(input int len);
        logic [KEY_W-1:0] key;
        key = '0;
        for (int i = 0; i < len; i++) begin
            key[KEY_W-1-BYTE_W*i -: BYTE_W] = BYTE_W'($urandom_range(1, 255));
        end
        return key;
    endfunction

    // Fills the bytes after the terminating zero with junk. The block must ignore
    // them, so the result names the same key as the original.
    function automatic logic [KEY_W-1:0] with_garbage_tail(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] out;
        int               len;
        out = key;
        len = string_length(key);
        for (int i = len + 1; i < KEY_NBYTES; i++) begin
            out[KEY_W-1-BYTE_W*i -: BYTE_W] = BYTE_W'($urandom_range(0, 255));
        end
        return out;
    endfunction

    // Swaps two characters: same byte sum and so the same home slot, but usually
    // a different key, which forces a collision and a probe walk.
    function automatic logic [KEY_W-1:0] permute_key(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0]  out;
        logic [BYTE_W-1:0] tmp;
        int                len;
        int                a;
        int                b;
        out = key;
        len = string_length(key);
        if (len < 2) begin
            return out;
        end
        a = $urandom_range(0, len - 1);
        b = $urandom_range(0, len - 2);
        if (b >= a) begin
            b++;
        end
        tmp = out[KEY_W-1-BYTE_W*a -: BYTE_W];
        out[KEY_W-1-BYTE_W*a -: BYTE_W] = out[KEY_W-1-BYTE_W*b -: BYTE_W];
        out[KEY_W-1-BYTE_W*b -: BYTE_W] = tmp;
        return out;
    endfunction

    function automatic logic [KEY_W-1:0] stored_key();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    // Offers one item on the input side and returns once it has been accepted.
    // The gap before it is drawn afresh for every item, and now and then the sender
    // switches to a stretch with no gaps at all.
    task automatic issue_op(input logic func, input logic [KEY_W-1:0] key);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_steady = !tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {key[HALF_W-1:0], key[KEY_W-1:HALF_W]};
        do begin
            @(posedge clk);
        end while (!s_tready);
        if (func == FUNC_INSERT && key[KEY_W-1 -: BYTE_W] != '0
                && key_pool.size() < KEY_POOL_CAP) begin
            key_pool.push_back(key);
        end
    endtask

    // Result side: the stall before each item is drawn in the same way as the
    // sender's gap, so the block sees its output held back at every stage of work.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                rx_steady = !rx_steady;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do begin
                @(posedge clk);
            end while (!m_tvalid);
            @(negedge clk);
        end
    end

    // The fill phase watches for the first "table full" answer to know when to stop.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready && m_tdata[STATUS_W-1:0] == ST_FULL) begin
            full_answer_seen <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which no item moves on either side.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int               choice;
        int               fills;
        logic             func;
        logic [KEY_W-1:0] key;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = FUNC_INSERT;
        s_tdata  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items on an empty table. The comments name the case that each
        // item covers.
        issue_op(FUNC_SEARCH, {8'h41, 120'h0});                 // miss on an empty table
        issue_op(FUNC_INSERT, '0);                               // empty key, no change
        issue_op(FUNC_SEARCH, '0);
        issue_op(FUNC_INSERT, {8'h00, {15{8'hA5}}});             // empty key with junk behind
        issue_op(FUNC_INSERT, {16{8'hFF}});                      // largest sum, wraps the modulo
        issue_op(FUNC_SEARCH, {16{8'hFF}});
        issue_op(FUNC_INSERT, {8'h41, 120'h0});
        issue_op(FUNC_INSERT, {8'h41, 120'h0});                  // already present
        issue_op(FUNC_INSERT, {8'h41, 8'h42, 112'h0});
        issue_op(FUNC_INSERT, {8'h42, 8'h41, 112'h0});           // anagram, probes one slot on
        issue_op(FUNC_SEARCH, {8'h42, 8'h41, 112'h0});
        issue_op(FUNC_SEARCH, {8'h41, 8'h43, 112'h0});           // walks past a neighbour, misses
        issue_op(FUNC_INSERT, {8'h41, 8'h42, 8'h00, {13{8'h5A}}}); // junk after the terminator
        issue_op(FUNC_SEARCH, {8'h42, 8'h41, 8'h00, {13{8'hC3}}});
        issue_op(FUNC_INSERT, {8'hFF, 8'hFF, 8'hFF, 8'hF3, 96'h0}); // home in the last slot
        issue_op(FUNC_INSERT, {8'hF3, 8'hFF, 8'hFF, 8'hFF, 96'h0}); // probe wraps to slot zero
        issue_op(FUNC_SEARCH, {8'hFF, 8'hF3, 8'hFF, 8'hFF, 96'h0}); // miss after the wrap
        issue_op(FUNC_INSERT, {8'hFF, 8'hFF, 8'hF3, 8'hFF, 96'h0});
        issue_op(FUNC_INSERT, {16{8'h80}});
        issue_op(FUNC_INSERT, {{15{8'h01}}, 8'h00});             // fifteen characters
        issue_op(FUNC_SEARCH, {{15{8'h01}}, 8'h7E});             // sixteen characters, differs
        issue_op(FUNC_SEARCH, {{15{8'h01}}, 8'h00});
        issue_op(FUNC_INSERT, {8'h01, 120'h0});
        issue_op(FUNC_SEARCH, {8'h01, 8'h00, {14{8'hFF}}});
        issue_op(FUNC_INSERT, {8'h7F, 8'h80, 112'h0});

        // Random mix on a table that fills up to about half: new keys, repeats,
        // anagrams that collide, short keys crowding the low slots, and empty keys.
        for (int n = 0; n < 1150; n++) begin
            choice = $urandom_range(0, 99);
            if (choice < 30) begin
                func = FUNC_INSERT;
                key  = random_string($urandom_range(1, KEY_NBYTES));
                if ($urandom_range(0, 3) == 0) begin
                    key = with_garbage_tail(key);
                end
            end else if (choice < 45) begin
                func = FUNC_INSERT;
                key  = stored_key();
                if ($urandom_range(0, 1) == 0) begin
                    key = with_garbage_tail(key);
                end
            end else if (choice < 65) begin
                func = FUNC_SEARCH;
                key  = with_garbage_tail(stored_key());
            end else if (choice < 75) begin
                func = FUNC_SEARCH;
                key  = random_string($urandom_range(1, KEY_NBYTES));
            end else if (choice < 85) begin
                func = 1'($urandom_range(0, 1));
                key  = permute_key(stored_key());
            end else if (choice < 90) begin
                func = 1'($urandom_range(0, 1));
                key  = {8'h00, 120'($urandom()) ^ {$urandom(), $urandom(), $urandom(), 24'h0}};
            end else begin
                func = 1'($urandom_range(0, 1));
                key  = with_garbage_tail(random_string($urandom_range(1, 2)));
            end
            issue_op(func, key);
        end

        // Fill the remaining slots with long keys until the block answers that
        // the table is full. The cap only guards against a block that never does.
        fills = 0;
        while (!full_answer_seen && fills < 1100) begin
            issue_op(FUNC_INSERT, random_string(KEY_NBYTES));
            fills++;
        end

        // A full table: stored keys are still found, new inserts report full,
        // and a search for an absent key walks every slot before it misses.
        for (int n = 0; n < 250; n++) begin
            choice = $urandom_range(0, 99);
            if (choice < 35) begin
                func = FUNC_SEARCH;
                key  = with_garbage_tail(stored_key());
            end else if (choice < 55) begin
                func = FUNC_INSERT;
                key  = stored_key();
            end else if (choice < 65) begin
                func = FUNC_INSERT;
                key  = random_string($urandom_range(1, KEY_NBYTES));
            end else if (choice < 75) begin
                func = FUNC_SEARCH;
                key  = random_string($urandom_range(1, KEY_NBYTES));
            end else if (choice < 85) begin
                func = 1'($urandom_range(0, 1));
                key  = {8'h00, 120'($urandom()) ^ {$urandom(), $urandom(), $urandom(), 24'h0}};
            end else begin
                func = 1'($urandom_range(0, 1));
                key  = permute_key(stored_key());
            end
            issue_op(func, key);
        end

        @(negedge clk);
        s_tvalid = 1'b0;

        // Every item has been accepted; wait for the last answers, then give any
        // stray output a little time to show itself.
        while (pending_count != 0) begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
